// ===== hdl/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad press detector package
// Shared constants, function codes and the result record used by the
// detector engine and the top level.
// ----------------------------------------------------------------------------
package kpd_pkg;

   // Number of keys in the matrix; map bits at and above this are ignored.
   localparam int KEY_COUNT = 16;

   // Widths of the item fields.
   localparam int MAP_W   = 16;
   localparam int COUNT_W = 16;
   localparam int FUNC_W  = 2;
   localparam int RSP_W   = 24;

   // Mask of the key bits that take part in a scan.
   localparam logic [MAP_W-1:0] KEY_BITS_MASK =
      (KEY_COUNT >= MAP_W) ? {MAP_W{1'b1}} : MAP_W'((64'd1 << KEY_COUNT) - 64'd1);

   // Hold count threshold after reset.
   localparam logic [COUNT_W-1:0] LONG_TICKS_RESET = COUNT_W'(30);

   // Saturation value of the hold counter.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Function codes carried on the request tuser.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SCAN      = 2'd0,
      FUNC_READ_KEY  = 2'd1,
      FUNC_READ_LONG = 2'd2,
      FUNC_NOP       = 2'd3
   } func_type;

   // One result beat before packing.
   typedef struct packed {
      logic             key_held;
      logic             long_press;
      logic             multi_key;
      logic [MAP_W-1:0] key_mask;
   } result_type;

endpackage

// ===== hdl/kpd_engine.sv =====
// ----------------------------------------------------------------------------
// Keypad press detector engine
// Holds the scan state and the threshold register, works out the result
// of one item combinationally and commits the new state when it advances.
// ----------------------------------------------------------------------------
module kpd_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [15:0]              csr_wdata,
   input  logic                     step,
   input  kpd_pkg::func_type        func,
   input  logic [kpd_pkg::MAP_W-1:0] key_map,
   output kpd_pkg::result_type      result
);
   import kpd_pkg::*;

   logic [COUNT_W-1:0] long_ticks_ff;
   logic [MAP_W-1:0]   previous_map_ff, previous_map_in;
   logic               held_ff, held_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [MAP_W-1:0]   released_ff, released_in;
   logic               long_ff, long_in;
   logic [MAP_W-1:0]   map;
   logic [COUNT_W-1:0] count_inc;
   logic               released_single;

   // Threshold register, written whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= LONG_TICKS_RESET;
      end else if (csr_wen) begin
         long_ticks_ff <= csr_wdata;
      end
   end

   assign map = key_map & KEY_BITS_MASK;

   // The hold counter advances while a key is held and sticks at its top.
   assign count_inc = (held_ff && count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;

   // A latched key is a single key when exactly one bit is set.
   assign released_single = (released_ff & (released_ff - MAP_W'(1))) == '0;

   // Next state and result for the item in the input register.
   always_comb begin
      previous_map_in = previous_map_ff;
      held_in         = held_ff;
      count_in        = count_ff;
      released_in     = released_ff;
      long_in         = long_ff;
      result          = '0;
      case (func)
         FUNC_SCAN: begin
            count_in        = count_inc;
            previous_map_in = map;
            if (map != previous_map_ff) begin
               if (map == '0) begin
                  held_in     = 1'b0;
                  released_in = previous_map_ff;
                  if (count_inc > long_ticks_ff) begin
                     long_in = 1'b1;
                  end
                  count_in = '0;
               end else begin
                  held_in = 1'b1;
               end
            end
         end
         FUNC_READ_KEY: begin
            released_in = '0;
            if (released_ff != '0) begin
               if (released_single) begin
                  result.key_mask = released_ff;
               end else begin
                  result.multi_key = 1'b1;
               end
            end
         end
         FUNC_READ_LONG: begin
            result.long_press = long_ff;
            long_in           = 1'b0;
         end
         default: begin
         end
      endcase
      result.key_held = held_in;
   end

   // Commit the state when the item moves on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_map_ff <= '0;
         held_ff         <= 1'b0;
         count_ff        <= '0;
         released_ff     <= '0;
         long_ff         <= 1'b0;
      end else if (step) begin
         previous_map_ff <= previous_map_in;
         held_ff         <= held_in;
         count_ff        <= count_in;
         released_ff     <= released_in;
         long_ff         <= long_in;
      end
   end

endmodule

// ===== hdl/matrix_keypad_press_detector.sv =====
// ----------------------------------------------------------------------------
// Matrix keypad press detector
// Tracks a 4x4 key matrix scan by scan, latches released keys and flags
// long presses; read requests return and clear what was latched.
// ----------------------------------------------------------------------------
// Usage:
// Each request beat carries the key map in req_tdata and the function in
// req_tuser (scan, read key, read long flag, no operation). Every request
// beat gives exactly one response beat, in order.
// A beat is held in an input register, worked out in one pass of logic
// and stored in the response register, which offers the response. One
// beat is taken per cycle when the receiver keeps rsp_tready high.
// When the receiver stalls, the response register holds its beat and the
// input register still takes one more beat; after that req_tready drops
// until the response is taken.
// The long-press threshold is written through csr_wen/csr_wdata; the user must
// write it only while the block is idle, which the block does not enforce. Reset
// clears all scan state, empties both registers, sets the threshold to 30 ticks.
// ----------------------------------------------------------------------------
module matrix_keypad_press_detector (
   input  logic        clock,
   input  logic        reset,
   // Configuration: long press threshold in ticks
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key_map
   input  logic [1:0]  req_tuser,   // [1:0] func
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] key_mask, [16] multi_key,
                                    // [17] long_press, [18] key_held, [23:19] zero
);
   import kpd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   func_type           func_ff;
   logic [MAP_W-1:0]   map_ff;
   logic               out_valid_ff, out_valid_in;
   result_type         out_data_ff;
   result_type         result;
   logic               advance;
   logic               req_take;

   // The input beat moves on when the response register is free or emptying.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Input register control.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Response register control.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_tuser);
         map_ff  <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   kpd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .func      (func_ff),
      .key_map   (map_ff),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W - $bits(result_type))'(0), out_data_ff};

endmodule

// ===== hdl/kpd_checker.sv =====
// ----------------------------------------------------------------------------
// Keypad press detector checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module kpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled beat stays put.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A reported key is a single key.
   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[15:0]))
      else $error("key mask has several bits set");

   // Key, multi-key and long-press reports never share a beat.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[17], rsp_tdata[16], |rsp_tdata[15:0]}))
      else $error("response mixes two kinds of report");

   // Padding bits are zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] == 5'd0)
      else $error("response padding not zero");

endmodule

bind matrix_keypad_press_detector kpd_checker u_kpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/matrix_keypad_press_detector_tb.sv =====
// ----------------------------------------------------------------------------
// Matrix keypad press detector testbench
// Drives scan, read and no-operation beats into the detector, predicts
// every response beat from its own model of the scan state and compares
// the responses field by field. The run covers several long-press
// thresholds, random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module matrix_keypad_press_detector_tb;
   import kpd_pkg::*;

   // One request beat before packing.
   typedef struct packed {
      func_type         func;
      logic [MAP_W-1:0] key_map;
   } keypad_req_t;

   localparam int unsigned STALL_LIMIT     = 5000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES   = 6;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] key_map
   logic [1:0]  req_tuser  = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] key_mask, [16] multi_key,
                                   // [17] long_press, [18] key_held, [23:19] zero

   matrix_keypad_press_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and expectation stores.
   keypad_req_t scan_beats_to_send[$];
   result_type  predicted_responses[$];

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned hold_off_asked = 0;
   int unsigned fail_count     = 0;
   bit          req_beat_taken = 1'b0;

   // Predicted scan state.
   logic [COUNT_W-1:0] long_ticks  = LONG_TICKS_RESET;
   logic [MAP_W-1:0]   last_map    = '0;
   logic               key_down    = 1'b0;
   logic [COUNT_W-1:0] hold_ticks  = '0;
   logic [MAP_W-1:0]   latched_key = '0;
   logic               long_seen   = 1'b0;

   // Advances the predicted state by one accepted request beat.
   function automatic result_type detect_step(func_type op, logic [MAP_W-1:0] raw_map);
      result_type       r;
      logic [MAP_W-1:0] map;
      logic [MAP_W-1:0] k;
      r = '0;
      map = raw_map & KEY_BITS_MASK;
      case (op)
         FUNC_SCAN: begin
            if (key_down && hold_ticks != COUNT_MAX)
               hold_ticks = hold_ticks + COUNT_W'(1);
            if (map != last_map) begin
               if (map == '0) begin
                  // Release: latch what was down and judge the hold length.
                  key_down = 1'b0;
                  latched_key = last_map;
                  if (hold_ticks > long_ticks)
                     long_seen = 1'b1;
                  hold_ticks = '0;
               end else begin
                  key_down = 1'b1;
               end
            end
            last_map = map;
         end
         FUNC_READ_KEY: begin
            k = latched_key;
            latched_key = '0;
            if (k != '0) begin
               if ((k & (k - MAP_W'(1))) == '0)
                  r.key_mask = k;
               else
                  r.multi_key = 1'b1;
            end
         end
         FUNC_READ_LONG: begin
            r.long_press = long_seen;
            long_seen = 1'b0;
         end
         default: ;
      endcase
      r.key_held = key_down;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [MAP_W-1:0] got, logic [MAP_W-1:0] want);
      $display("%0t: response %s is %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // Request driver: offers queued beats with random gaps, holds a beat until taken.
   always @(negedge clock) begin
      keypad_req_t beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_beat_taken) begin
         // Beat still waiting for the block; keep it steady.
      end else if (scan_beats_to_send.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         beat = scan_beats_to_send.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= beat.key_map;
         req_tuser  <= beat.func;
      end else begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         req_tuser  <= 2'($urandom);
      end
   end

   // Response receiver: random stalls, plus a long hold-off when one is asked for.
   always @(negedge clock) begin
      static int unsigned hold_off_served = 0;
      static int unsigned hold_off_left   = 0;
      if (hold_off_served != hold_off_asked) begin
         hold_off_served++;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: checks response beats, predicts accepted request beats, runs the watchdog.
   always @(posedge clock) begin
      static int unsigned quiet_cycles = 0;
      result_type got;
      result_type want;
      req_beat_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[18:0]);
            if (rsp_tdata[23:19] !== '0)
               report_mismatch("padding", MAP_W'(rsp_tdata[23:19]), '0);
            if (predicted_responses.size() == 0) begin
               $display("%0t: response beat %h with none expected", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_responses.pop_front();
               if (got.key_mask !== want.key_mask)
                  report_mismatch("key_mask", got.key_mask, want.key_mask);
               if (got.multi_key !== want.multi_key)
                  report_mismatch("multi_key", MAP_W'(got.multi_key),
                                  MAP_W'(want.multi_key));
               if (got.long_press !== want.long_press)
                  report_mismatch("long_press", MAP_W'(got.long_press),
                                  MAP_W'(want.long_press));
               if (got.key_held !== want.key_held)
                  report_mismatch("key_held", MAP_W'(got.key_held),
                                  MAP_W'(want.key_held));
            end
         end
         if (req_tvalid && req_tready) begin
            req_beat_taken = 1'b1;
            predicted_responses.push_back(detect_step(func_type'(req_tuser), req_tdata));
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_beat(func_type f, logic [MAP_W-1:0] m);
      keypad_req_t b;
      b.func = f;
      b.key_map = m;
      scan_beats_to_send.push_back(b);
   endtask

   // Waits until every queued beat is sent and answered, then lets the block settle.
   task automatic wait_drained();
      while (scan_beats_to_send.size() != 0 || predicted_responses.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [COUNT_W-1:0] ticks);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= ticks;
      long_ticks = ticks;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [MAP_W-1:0] random_pressed_map();
      int unsigned      sel;
      logic [MAP_W-1:0] m;
      sel = $urandom_range(99);
      if (sel < 65)
         m = MAP_W'(1) << $urandom_range(MAP_W - 1);
      else if (sel < 90)
         m = (MAP_W'(1) << $urandom_range(MAP_W - 1)) | (MAP_W'(1) << $urandom_range(MAP_W - 1));
      else
         m = MAP_W'($urandom);
      if (m == '0)
         m = 16'h8001;
      return m;
   endfunction

   // One press: hold for a while, maybe slide to other keys, usually release, then maybe read back.
   task automatic queue_press_run(output int unsigned added);
      logic [MAP_W-1:0] map;
      int unsigned      max_hold;
      int unsigned      hold;
      added = 0;
      max_hold = (long_ticks < 34) ? long_ticks + 6 : 40;
      map = random_pressed_map();
      hold = $urandom_range(max_hold);
      repeat (hold + 1) begin
         queue_beat(FUNC_SCAN, map);
         added++;
      end
      if ($urandom_range(99) < 20) begin
         map = random_pressed_map();
         repeat ($urandom_range(1, 4)) begin
            queue_beat(FUNC_SCAN, map);
            added++;
         end
      end
      if ($urandom_range(99) < 85) begin
         repeat ($urandom_range(1, 2)) begin
            queue_beat(FUNC_SCAN, '0);
            added++;
         end
      end
      if ($urandom_range(99) < 80) begin
         queue_beat(FUNC_READ_KEY, MAP_W'($urandom));
         added++;
      end
      if ($urandom_range(99) < 70) begin
         queue_beat(FUNC_READ_LONG, MAP_W'($urandom));
         added++;
      end
      if ($urandom_range(99) < 10) begin
         queue_beat(FUNC_NOP, MAP_W'($urandom));
         added++;
      end
   endtask

   task automatic run_random_phase(logic [COUNT_W-1:0] ticks, int unsigned send_idle,
                                   int unsigned stall, int unsigned beats, bit squeeze);
      int unsigned queued;
      int unsigned added;
      write_threshold(ticks);
      send_idle_pct = send_idle;
      rsp_stall_pct = stall;
      queued = 0;
      while (queued < beats) begin
         if ($urandom_range(99) < 15) begin
            // Noise: any function code with any data.
            queue_beat(func_type'($urandom_range(3)), MAP_W'($urandom));
            queued++;
         end else begin
            queue_press_run(added);
            queued += added;
         end
      end
      if (squeeze)
         hold_off_asked++;
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset threshold and no idling.
      queue_beat(FUNC_NOP, 16'hFFFF);
      queue_beat(FUNC_READ_KEY, 16'h0000);
      queue_beat(FUNC_READ_LONG, 16'hFFFF);
      queue_beat(FUNC_SCAN, 16'h0001);
      queue_beat(FUNC_SCAN, 16'h0001);
      queue_beat(FUNC_SCAN, 16'h0000);
      queue_beat(FUNC_READ_KEY, 16'hFFFF);
      queue_beat(FUNC_READ_KEY, 16'h0000);
      // A second release overwrites an unread latched key.
      queue_beat(FUNC_SCAN, 16'h8000);
      queue_beat(FUNC_SCAN, 16'h0000);
      queue_beat(FUNC_SCAN, 16'h0400);
      queue_beat(FUNC_SCAN, 16'h0000);
      queue_beat(FUNC_READ_KEY, 16'h5555);
      // All keys down at once reads back as several keys.
      queue_beat(FUNC_SCAN, 16'hFFFF);
      queue_beat(FUNC_SCAN, 16'h0000);
      queue_beat(FUNC_READ_KEY, 16'hAAAA);
      // A change between two non-zero maps keeps the key held.
      queue_beat(FUNC_SCAN, 16'h0010);
      queue_beat(FUNC_SCAN, 16'h0030);
      queue_beat(FUNC_NOP, 16'h0000);
      queue_beat(FUNC_SCAN, 16'h0000);
      queue_beat(FUNC_READ_KEY, 16'h0000);
      queue_beat(FUNC_READ_LONG, 16'h0000);
      wait_drained();

      // Random part over several thresholds and idling patterns.
      run_random_phase(16'd0, 38, 85, 340, 1'b0);
      run_random_phase(16'($urandom_range(1, 12)), 38, 85, 340, 1'b0);
      run_random_phase(16'd65535, 85, 38, 340, 1'b0);
      run_random_phase(16'd5, 85, 38, 340, 1'b0);
      run_random_phase(16'd2, 0, 0, 340, 1'b1);
      run_random_phase(16'd30, 0, 0, 340, 1'b0);

      if (predicted_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, predicted_responses.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/kpd_pkg.sv
hdl/kpd_engine.sv
hdl/matrix_keypad_press_detector.sv
hdl/kpd_checker.sv
tb/matrix_keypad_press_detector_tb.sv
